### rtl/text_console_cell_engine_assert.svh
// assertion macros for the text console cell engine
`ifndef TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_ENGINE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define TCCE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define TCCE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tcce_pkg.sv
// shared constants, types and address helpers of the text console cell engine
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_SPACES   = 4;
    localparam int RESULT_LIMIT = 6;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int REP_W  = $clog2(TAB_SPACES + 1);
    localparam int RCNT_W = $clog2(RESULT_LIMIT + 1);

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = CHAR_W + COLOR_W;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 5;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 4'd15;
    localparam logic [ROW_W-1:0]   FIRST_ROW_RST  = 5'd0;
    localparam logic [ROW_W-1:0]   END_ROW_RST    = ROW_W'(ROWS);

    typedef enum logic [CMD_W-1:0] {
        CMD_PRINT = 2'd0,
        CMD_PUT   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        EVT_WRITE  = 2'd0,
        EVT_SCROLL = 2'd1,
        EVT_READ   = 2'd2,
        EVT_CLEAR  = 2'd3
    } evt_t;

    typedef enum logic [IDX_W-1:0] {
        REG_TEXT_COLOR = 2'd0,
        REG_FIRST_ROW  = 2'd1,
        REG_END_ROW    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0] text_color;
        logic [ROW_W-1:0]   first_row;
        logic [ROW_W-1:0]   end_row;
    } cfg_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [CHAR_W-1:0]  ch;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COLOR_W-1:0] color;
    } item_t;

    typedef struct packed {
        evt_t               evt;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
    } res_t;

    typedef struct packed {
        logic res_valid;
        logic cmd_done;
        res_t res;
    } emit_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic row_ok(input logic [ROW_W-1:0] r);
        return 32'(r) < 32'(ROWS);
    endfunction

    function automatic logic col_ok(input logic [COL_W-1:0] c);
        return 32'(c) < 32'(COLUMNS);
    endfunction

    // end row limited to the store
    function automatic logic [ROW_W-1:0] end_lim(input logic [ROW_W-1:0] e);
        return row_ok(e) ? e : ROW_W'(ROWS);
    endfunction

    function automatic logic [CNT_W-1:0] row_base(input logic [ROW_W-1:0] r);
        return CNT_W'(32'(r) * COLUMNS);
    endfunction

    function automatic logic [CNT_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        return row_base(r) + CNT_W'(c);
    endfunction

endpackage

### rtl/tcce_cell_ram.sv
// cell store: one write and one registered read port
`timescale 1ns / 1ps

module tcce_cell_ram
(
    input  logic                           clk,
    input  tcce_pkg::ram_req_t             req,
    output logic [tcce_pkg::CELL_W-1:0]    rdata
);
    import tcce_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tcce_seq.sv
// command sequencer: cursor, print, scroll, clear and cell access over the store
`timescale 1ns / 1ps

module tcce_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tcce_pkg::item_t               item,
    input  tcce_pkg::cfg_t                cfg,
    output tcce_pkg::emit_t               emit,
    input  logic                          emit_ready,
    output tcce_pkg::ram_req_t            ram,
    input  logic [tcce_pkg::CELL_W-1:0]   ram_rdata
);
    import tcce_pkg::*;

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_PRINT,
        S_PUT,
        S_RD_REQ,
        S_RD_DATA,
        S_SCR_COPY,
        S_SCR_CLR,
        S_SCR_EMIT,
        S_CLR_EMIT,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [CNT_W-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0]    stop_reg, stop_next;
    logic [ADDR_W-1:0]   waddr_reg, waddr_next;
    logic                wpend_reg, wpend_next;
    logic [ROW_W-1:0]    line_reg, line_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic [REP_W-1:0]    rep_reg, rep_next;
    logic [ROW_W-1:0]    irow_reg, irow_next;
    logic [COL_W-1:0]    icol_reg, icol_next;
    logic [COLOR_W-1:0]  icolor_reg, icolor_next;

    logic [ROW_W-1:0]    e_lim;
    logic [ROW_W-1:0]    bot_row;
    logic [CNT_W-1:0]    src_addr;
    logic [CNT_W-1:0]    cur_addr;
    logic [CNT_W-1:0]    put_addr;
    logic [COL_W-1:0]    col_inc;
    logic                cur_in;
    logic                item_in;

    assign e_lim    = end_lim(cfg.end_row);
    assign bot_row  = cfg.end_row - 5'd1;
    assign src_addr = addr_reg + CNT_W'(COLUMNS);
    assign cur_addr = cell_addr(line_reg, col_reg);
    assign put_addr = cell_addr(irow_reg, icol_reg);
    assign col_inc  = col_reg + 7'd1;
    assign cur_in   = row_ok(line_reg) && col_ok(col_reg);
    assign item_in  = row_ok(irow_reg) && col_ok(icol_reg);
    assign s_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        addr_next   = addr_reg;
        stop_next   = stop_reg;
        waddr_next  = waddr_reg;
        wpend_next  = wpend_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        ch_next     = ch_reg;
        rep_next    = rep_reg;
        irow_next   = irow_reg;
        icol_next   = icol_reg;
        icolor_next = icolor_reg;
        emit        = '0;
        ram         = '0;

        unique case (state_reg)
            S_FILL:
            begin
                if (addr_reg < stop_reg)
                begin
                    ram.we    = 1'b1;
                    ram.waddr = addr_reg[ADDR_W-1:0];
                    ram.wdata = '0;
                    addr_next = addr_reg + 1'b1;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end

            S_IDLE:
            begin
                if (s_valid)
                begin
                    irow_next   = item.row;
                    icol_next   = item.col;
                    icolor_next = item.color;
                    ch_next     = item.ch;
                    rep_next    = '0;
                    unique case (item.cmd)
                        CMD_PRINT:
                        begin
                            if (item.ch == CHAR_NUL)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                if (item.ch == CHAR_TAB)
                                begin
                                    ch_next  = CHAR_SPACE;
                                    rep_next = REP_W'(TAB_SPACES - 1);
                                end
                                state_next = S_PRINT;
                            end
                        end
                        CMD_PUT:
                        begin
                            if (item.ch != CHAR_NUL && row_ok(item.row) && col_ok(item.col))
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        CMD_READ:
                        begin
                            state_next = S_RD_REQ;
                        end
                        CMD_CLEAR:
                        begin
                            if (cfg.first_row < e_lim)
                            begin
                                addr_next = row_base(cfg.first_row);
                                stop_next = row_base(e_lim);
                            end
                            else
                            begin
                                addr_next = '0;
                                stop_next = '0;
                            end
                            ret_next   = S_CLR_EMIT;
                            state_next = S_FILL;
                        end
                    endcase
                end
            end

            S_PRINT:
            begin
                if (line_reg == cfg.end_row)
                begin
                    // pending scroll: copy usable rows up by one
                    if (({1'b0, cfg.first_row} + 6'd1) < {1'b0, e_lim})
                    begin
                        addr_next = row_base(cfg.first_row);
                        stop_next = row_base(e_lim - 5'd1);
                    end
                    else
                    begin
                        addr_next = '0;
                        stop_next = '0;
                    end
                    wpend_next = 1'b0;
                    state_next = S_SCR_COPY;
                end
                else if (ch_reg == CHAR_NL)
                begin
                    line_next  = line_reg + 5'd1;
                    col_next   = '0;
                    state_next = S_DONE;
                end
                else if (emit_ready)
                begin
                    if (cur_in)
                    begin
                        ram.we    = 1'b1;
                        ram.waddr = cur_addr[ADDR_W-1:0];
                        ram.wdata = {cfg.text_color, ch_reg};
                    end
                    emit.res_valid = 1'b1;
                    emit.res.evt   = EVT_WRITE;
                    emit.res.row   = line_reg;
                    emit.res.col   = col_reg;
                    emit.res.ch    = ch_reg;
                    emit.res.color = cfg.text_color;
                    if (col_ok(col_inc))
                    begin
                        col_next = col_inc;
                    end
                    else
                    begin
                        line_next = line_reg + 5'd1;
                        col_next  = '0;
                    end
                    if (rep_reg != '0)
                    begin
                        rep_next = rep_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SCR_COPY:
            begin
                if (wpend_reg)
                begin
                    ram.we    = 1'b1;
                    ram.waddr = waddr_reg;
                    ram.wdata = ram_rdata;
                end
                if (addr_reg < stop_reg)
                begin
                    ram.re     = 1'b1;
                    ram.raddr  = src_addr[ADDR_W-1:0];
                    waddr_next = addr_reg[ADDR_W-1:0];
                    wpend_next = 1'b1;
                    addr_next  = addr_reg + 1'b1;
                end
                else
                begin
                    wpend_next = 1'b0;
                    state_next = S_SCR_CLR;
                end
            end

            S_SCR_CLR:
            begin
                line_next = bot_row;
                if (row_ok(bot_row))
                begin
                    addr_next = row_base(bot_row);
                    stop_next = row_base(bot_row) + CNT_W'(COLUMNS);
                end
                else
                begin
                    addr_next = '0;
                    stop_next = '0;
                end
                ret_next   = S_SCR_EMIT;
                state_next = S_FILL;
            end

            S_SCR_EMIT:
            begin
                if (emit_ready)
                begin
                    emit.res_valid = 1'b1;
                    emit.res.evt   = EVT_SCROLL;
                    emit.res.row   = line_reg;
                    state_next     = S_PRINT;
                end
            end

            S_PUT:
            begin
                if (emit_ready)
                begin
                    ram.we         = 1'b1;
                    ram.waddr      = put_addr[ADDR_W-1:0];
                    ram.wdata      = {icolor_reg, ch_reg};
                    emit.res_valid = 1'b1;
                    emit.res.evt   = EVT_WRITE;
                    emit.res.row   = irow_reg;
                    emit.res.col   = icol_reg;
                    emit.res.ch    = ch_reg;
                    emit.res.color = icolor_reg;
                    state_next     = S_DONE;
                end
            end

            S_RD_REQ:
            begin
                if (item_in)
                begin
                    ram.re    = 1'b1;
                    ram.raddr = put_addr[ADDR_W-1:0];
                end
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                if (emit_ready)
                begin
                    emit.res_valid = 1'b1;
                    emit.res.evt   = EVT_READ;
                    emit.res.row   = irow_reg;
                    emit.res.col   = icol_reg;
                    if (item_in)
                    begin
                        emit.res.ch    = ram_rdata[CHAR_W-1:0];
                        emit.res.color = ram_rdata[CELL_W-1:CHAR_W];
                    end
                    state_next = S_DONE;
                end
            end

            S_CLR_EMIT:
            begin
                if (emit_ready)
                begin
                    line_next      = cfg.first_row;
                    emit.res_valid = 1'b1;
                    emit.res.evt   = EVT_CLEAR;
                    state_next     = S_DONE;
                end
            end

            S_DONE:
            begin
                if (emit_ready)
                begin
                    emit.cmd_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_FILL;
            ret_reg    <= S_IDLE;
            addr_reg   <= '0;
            stop_reg   <= CNT_W'(CELLS);
            waddr_reg  <= '0;
            wpend_reg  <= 1'b0;
            line_reg   <= FIRST_ROW_RST;
            col_reg    <= '0;
            ch_reg     <= '0;
            rep_reg    <= '0;
            irow_reg   <= '0;
            icol_reg   <= '0;
            icolor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            addr_reg   <= addr_next;
            stop_reg   <= stop_next;
            waddr_reg  <= waddr_next;
            wpend_reg  <= wpend_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            ch_reg     <= ch_next;
            rep_reg    <= rep_next;
            irow_reg   <= irow_next;
            icol_reg   <= icol_next;
            icolor_reg <= icolor_next;
        end
    end

endmodule

### rtl/tcce_out_stage.sv
// result holding word, per-command limit, last marking and output register
`timescale 1ns / 1ps

module tcce_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  tcce_pkg::emit_t    emit,
    output logic               emit_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output tcce_pkg::res_t     m_res,
    output logic               m_last
);
    import tcce_pkg::*;

    logic               ov_reg, ov_next;
    res_t               out_reg, out_next;
    logic               last_reg, last_next;
    logic               hold_valid_reg, hold_valid_next;
    res_t               hold_reg, hold_next;
    logic [RCNT_W-1:0]  cnt_reg, cnt_next;
    logic               slot_free;
    logic               push;
    logic               push_last;

    assign slot_free  = !ov_reg || m_ready;
    assign emit_ready = slot_free;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        cnt_next        = cnt_reg;
        push            = 1'b0;
        push_last       = 1'b0;

        // a word leaves the holding stage only once the next one or the end is known
        if (emit.res_valid && (cnt_reg < RCNT_W'(RESULT_LIMIT)))
        begin
            push            = hold_valid_reg;
            hold_next       = emit.res;
            hold_valid_next = 1'b1;
            cnt_next        = cnt_reg + 1'b1;
        end
        if (emit.cmd_done)
        begin
            push            = hold_valid_reg;
            push_last       = 1'b1;
            hold_valid_next = 1'b0;
            cnt_next        = '0;
        end

        ov_next   = ov_reg;
        out_next  = out_reg;
        last_next = last_reg;
        if (push)
        begin
            ov_next   = 1'b1;
            out_next  = hold_reg;
            last_next = push_last;
        end
        else if (m_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg         <= 1'b0;
            out_reg        <= '0;
            last_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            ov_reg         <= ov_next;
            out_reg        <= out_next;
            last_reg       <= last_next;
            hold_valid_reg <= hold_valid_next;
            hold_reg       <= hold_next;
            cnt_reg        <= cnt_next;
        end
    end

    assign m_valid = ov_reg;
    assign m_res   = out_reg;
    assign m_last  = last_reg;

endmodule

### rtl/text_console_cell_engine.sv
// a single print or put word passes the holding word and then the output register, a read
// word does so after the registered store read; a pending scroll first copies the usable
// rows up by one, clears the bottom row and emits a scroll word; a clear-screen command
// zeroes the usable rows before its clear word; a new command is taken only when idle again
// async active-low reset; then the store is zeroed one cell a cycle, input held off
`timescale 1ns / 1ps
`include "text_console_cell_engine_assert.svh"

module text_console_cell_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // char_code, row, col, put_color
    input  logic [tcce_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // command
    input  logic [tcce_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_row, out_col, out_char, out_color
    output logic [tcce_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // event_res
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcce_pkg::IDX_W-1:0]          cfg_index,
    input  logic [tcce_pkg::CFG_W-1:0]          cfg_data
);
    import tcce_pkg::*;

    cfg_t               cfg_reg;
    item_t              item;
    emit_t              emit;
    logic               emit_ready;
    ram_req_t           ram_req;
    logic [CELL_W-1:0]  ram_rdata;
    res_t               m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_color <= TEXT_COLOR_RST;
            cfg_reg.first_row  <= FIRST_ROW_RST;
            cfg_reg.end_row    <= END_ROW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TEXT_COLOR: cfg_reg.text_color <= cfg_data[COLOR_W-1:0];
                REG_FIRST_ROW:  cfg_reg.first_row  <= cfg_data[ROW_W-1:0];
                REG_END_ROW:    cfg_reg.end_row    <= cfg_data[ROW_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign item.cmd   = cmd_t'(s_axis_tuser);
    assign item.ch    = s_axis_tdata[7:0];
    assign item.row   = s_axis_tdata[12:8];
    assign item.col   = s_axis_tdata[19:13];
    assign item.color = s_axis_tdata[23:20];

    tcce_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .item       (item),
        .cfg        (cfg_reg),
        .emit       (emit),
        .emit_ready (emit_ready),
        .ram        (ram_req),
        .ram_rdata  (ram_rdata)
    );

    tcce_cell_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    tcce_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .emit_ready (emit_ready),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_res      (m_res),
        .m_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {m_res.color, m_res.ch, m_res.col, m_res.row};
    assign m_axis_tuser = m_res.evt;

    `TCCE_ASSERT_IMP(a_idle_quiet, s_axis_tready, !emit.res_valid && !emit.cmd_done, "result while idle")
    `TCCE_ASSERT_IMP(a_emit_room, emit.res_valid || emit.cmd_done, emit_ready, "word with no room")
    `TCCE_ASSERT_NXT(a_done_idle, emit.cmd_done, s_axis_tready, "not idle after command end")

endmodule

### sim/tb_text_console_cell_engine.sv
// self-checking testbench for the text console cell engine: directed table, then random command mix
`timescale 1ns / 1ps

module tb_text_console_cell_engine;

    import tcce_pkg::*;

    localparam int CYCLE_LIMIT   = 6000000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 100;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 56;

    typedef enum logic [1:0] {
        OUT_PREDICTED,
        OUT_ONE_CELL,
        OUT_SILENT
    } outcome_t;

    typedef struct packed {
        res_t res;
        logic last;
    } cell_event_t;

    typedef struct packed {
        item_t    it;
        outcome_t how;
        res_t     want;
    } probe_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    // console model state
    logic [CELL_W-1:0]  screen [CELLS];
    logic [ROW_W-1:0]   cur_line;
    logic [COL_W-1:0]   cur_col;
    logic [COLOR_W-1:0] pen_color;
    logic [ROW_W-1:0]   top_row;
    logic [ROW_W-1:0]   stop_row;

    res_t        step_words [$];
    cell_event_t pending_words [$];
    probe_t      probes [$];

    int errors;
    int cycles;
    int items_sent;
    int words_checked;
    int scrolls_seen;
    int hold_requests;
    int hold_served;
    bit quiet;

    text_console_cell_engine i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void note(input evt_t ev, input logic [ROW_W-1:0] r,
                                 input logic [COL_W-1:0] c, input logic [CHAR_W-1:0] ch,
                                 input logic [COLOR_W-1:0] pc);
        res_t w;
        if (step_words.size() < RESULT_LIMIT)
        begin
            w.evt   = ev;
            w.row   = r;
            w.col   = c;
            w.ch    = ch;
            w.color = pc;
            step_words.push_back(w);
        end
    endfunction

    function automatic void wipe_row(input logic [ROW_W-1:0] r);
        int c;
        if (int'(r) < ROWS)
        begin
            for (c = 0; c < COLUMNS; c++)
            begin
                screen[int'(r) * COLUMNS + c] = '0;
            end
        end
    endfunction

    function automatic void scroll_window();
        int lim;
        int r;
        int c;
        lim = (int'(stop_row) > ROWS) ? ROWS : int'(stop_row);
        for (r = int'(top_row); r + 1 < lim; r++)
        begin
            for (c = 0; c < COLUMNS; c++)
            begin
                screen[r * COLUMNS + c] = screen[(r + 1) * COLUMNS + c];
            end
        end
        cur_line = stop_row - 5'd1;
        wipe_row(cur_line);
        note(EVT_SCROLL, cur_line, '0, '0, '0);
    endfunction

    function automatic void write_glyph(input logic [CHAR_W-1:0] ch);
        if (int'(cur_line) < ROWS && int'(cur_col) < COLUMNS)
        begin
            screen[int'(cur_line) * COLUMNS + int'(cur_col)] = {pen_color, ch};
        end
        note(EVT_WRITE, cur_line, cur_col, ch, pen_color);
        cur_col = cur_col + 7'd1;
        if (int'(cur_col) >= COLUMNS)
        begin
            cur_line = cur_line + 5'd1;
            cur_col  = '0;
        end
    endfunction

    function automatic void console_step(input item_t it);
        logic [CELL_W-1:0] stored;
        int i;
        int lim;
        step_words.delete();
        case (it.cmd)
            CMD_PRINT:
            begin
                if (it.ch != CHAR_NUL)
                begin
                    if (cur_line == stop_row)
                    begin
                        scroll_window();
                    end
                    if (it.ch == CHAR_NL)
                    begin
                        cur_line = cur_line + 5'd1;
                        cur_col  = '0;
                    end
                    else if (it.ch == CHAR_TAB)
                    begin
                        for (i = 0; i < TAB_SPACES; i++)
                        begin
                            if (cur_line == stop_row)
                            begin
                                scroll_window();
                            end
                            write_glyph(CHAR_SPACE);
                        end
                    end
                    else
                    begin
                        write_glyph(it.ch);
                    end
                end
            end
            CMD_PUT:
            begin
                if (it.ch != CHAR_NUL && int'(it.row) < ROWS && int'(it.col) < COLUMNS)
                begin
                    screen[int'(it.row) * COLUMNS + int'(it.col)] = {it.color, it.ch};
                    note(EVT_WRITE, it.row, it.col, it.ch, it.color);
                end
            end
            CMD_READ:
            begin
                stored = '0;
                if (int'(it.row) < ROWS && int'(it.col) < COLUMNS)
                begin
                    stored = screen[int'(it.row) * COLUMNS + int'(it.col)];
                end
                note(EVT_READ, it.row, it.col, stored[CHAR_W-1:0], stored[CELL_W-1:CHAR_W]);
            end
            default:
            begin
                lim = (int'(stop_row) > ROWS) ? ROWS : int'(stop_row);
                for (i = int'(top_row); i < lim; i++)
                begin
                    wipe_row(ROW_W'(i));
                end
                cur_line = top_row;
                note(EVT_CLEAR, '0, '0, '0, '0);
            end
        endcase
    endfunction

    function automatic probe_t probe(input cmd_t cmd, input int ch, input int r, input int c,
                                     input int pc, input outcome_t how, input evt_t ev,
                                     input int er, input int ec, input int ech, input int epc);
        probe_t p;
        p.it.cmd     = cmd;
        p.it.ch      = CHAR_W'(ch);
        p.it.row     = ROW_W'(r);
        p.it.col     = COL_W'(c);
        p.it.color   = COLOR_W'(pc);
        p.how        = how;
        p.want.evt   = ev;
        p.want.row   = ROW_W'(er);
        p.want.col   = COL_W'(ec);
        p.want.ch    = CHAR_W'(ech);
        p.want.color = COLOR_W'(epc);
        return p;
    endfunction

    task automatic issue(input item_t it, input outcome_t how, input res_t typed);
        cell_event_t ev;
        int k;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.color, it.col, it.row, it.ch};
        s_axis_tuser  <= it.cmd;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        console_step(it);
        if (how == OUT_PREDICTED)
        begin
            for (k = 0; k < step_words.size(); k++)
            begin
                ev.res  = step_words[k];
                ev.last = (k == step_words.size() - 1);
                pending_words.push_back(ev);
            end
        end
        else if (how == OUT_ONE_CELL)
        begin
            ev.res  = typed;
            ev.last = 1'b1;
            pending_words.push_back(ev);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [COLOR_W-1:0] pc, input logic [ROW_W-1:0] first,
                              input logic [ROW_W-1:0] stop);
        logic [CFG_W-1:0] vals [3];
        reg_idx_t idx;
        int n;
        vals[0] = CFG_W'(pc);
        vals[1] = first;
        vals[2] = stop;
        for (n = 0; n < 3; n++)
        begin
            idx = reg_idx_t'(n);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[n];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            case (idx)
                REG_TEXT_COLOR: pen_color = vals[n][COLOR_W-1:0];
                REG_FIRST_ROW:  top_row   = vals[n];
                default:        stop_row  = vals[n];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold on request, checks every word
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        cell_event_t got;
        cell_event_t want;
        m_axis_tready <= 1'b0;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.res.evt   = evt_t'(m_axis_tuser);
                got.res.row   = m_axis_tdata[4:0];
                got.res.col   = m_axis_tdata[11:5];
                got.res.ch    = m_axis_tdata[19:12];
                got.res.color = m_axis_tdata[23:20];
                got.last      = m_axis_tlast;
                words_checked++;
                if (got.res.evt == EVT_SCROLL)
                begin
                    scrolls_seen++;
                end
                if (pending_words.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected word: ev %0d row %0d col %0d char %02h color %0d",
                                 got.res.evt, got.res.row, got.res.col, got.res.ch,
                                 got.res.color);
                    end
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("word %0d expected ev %0d row %0d col %0d char %02h color %0d last %0d",
                                     words_checked, want.res.evt, want.res.row, want.res.col,
                                     want.res.ch, want.res.color, want.last);
                            $display("        got      ev %0d row %0d col %0d char %02h color %0d last %0d",
                                     got.res.evt, got.res.row, got.res.col, got.res.ch,
                                     got.res.color, got.last);
                        end
                    end
                end
            end
            if (hold_served < hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        item_t it;
        res_t none;
        int ph;
        int k;
        int pick;
        int win_top [PHASES];
        int win_end [PHASES];
        logic [COLOR_W-1:0] pc;

        errors        = 0;
        cycles        = 0;
        items_sent    = 0;
        words_checked = 0;
        scrolls_seen  = 0;
        hold_requests = 0;
        hold_served   = 0;
        quiet         = 1'b0;
        none          = '0;
        win_top       = '{20, 0, 24, 12, 18, 0, 0};
        win_end       = '{23, 1, 25, 31, 6, 0, 25};

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;

        for (k = 0; k < CELLS; k++)
        begin
            screen[k] = '0;
        end
        pen_color = TEXT_COLOR_RST;
        top_row   = FIRST_ROW_RST;
        stop_row  = END_ROW_RST;
        cur_line  = FIRST_ROW_RST;
        cur_col   = '0;

        // after reset, extremes, ignored puts, tab, newline and a clear
        probes.push_back(probe(CMD_READ,  0,    0,  0,   0, OUT_ONE_CELL, EVT_READ,   0,  0,   0,    0));
        probes.push_back(probe(CMD_READ,  0,    24, 79,  0, OUT_ONE_CELL, EVT_READ,  24, 79,   0,    0));
        probes.push_back(probe(CMD_READ,  0,    31, 127, 15, OUT_ONE_CELL, EVT_READ, 31, 127, 0,    0));
        probes.push_back(probe(CMD_PRINT, 0,    0,  0,   0, OUT_SILENT,   EVT_WRITE,  0,  0,   0,    0));
        probes.push_back(probe(CMD_PRINT, 'h41, 0,  0,   0, OUT_ONE_CELL, EVT_WRITE,  0,  0, 'h41, 15));
        probes.push_back(probe(CMD_PUT,   'hFF, 24, 79,  0, OUT_ONE_CELL, EVT_WRITE, 24, 79, 'hFF,  0));
        probes.push_back(probe(CMD_READ,  0,    24, 79,  0, OUT_ONE_CELL, EVT_READ,  24, 79, 'hFF,  0));
        probes.push_back(probe(CMD_PUT,   'h55, 24, 80,  5, OUT_SILENT,   EVT_WRITE,  0,  0,   0,    0));
        probes.push_back(probe(CMD_PUT,   'h55, 25, 0,   5, OUT_SILENT,   EVT_WRITE,  0,  0,   0,    0));
        probes.push_back(probe(CMD_PUT,   'hFF, 31, 127, 15, OUT_SILENT,  EVT_WRITE,  0,  0,   0,    0));
        probes.push_back(probe(CMD_PUT,   0,    3,  3,   7, OUT_SILENT,   EVT_WRITE,  0,  0,   0,    0));
        probes.push_back(probe(CMD_PRINT, CHAR_TAB, 0, 0, 0, OUT_PREDICTED, EVT_WRITE, 0,  0,   0,    0));
        probes.push_back(probe(CMD_PRINT, CHAR_NL,  0, 0, 0, OUT_SILENT,    EVT_WRITE, 0,  0,   0,    0));
        probes.push_back(probe(CMD_PRINT, 'hFF, 0,  0,   0, OUT_ONE_CELL, EVT_WRITE,  1,  0, 'hFF, 15));
        probes.push_back(probe(CMD_PUT,   'h01, 0,  0,  15, OUT_ONE_CELL, EVT_WRITE,  0,  0, 'h01, 15));
        probes.push_back(probe(CMD_READ,  0,    0,  0,   0, OUT_ONE_CELL, EVT_READ,   0,  0, 'h01, 15));
        probes.push_back(probe(CMD_READ,  0,    0,  3,   0, OUT_PREDICTED, EVT_READ,  0,  0,   0,    0));
        probes.push_back(probe(CMD_CLEAR, 'hFF, 31, 127, 15, OUT_ONE_CELL, EVT_CLEAR, 0,  0,   0,    0));
        probes.push_back(probe(CMD_READ,  0,    24, 79,  0, OUT_ONE_CELL, EVT_READ,  24, 79,   0,    0));
        probes.push_back(probe(CMD_PRINT, 'h7A, 0,  0,   0, OUT_PREDICTED, EVT_WRITE, 0,  0,   0,    0));
        probes.push_back(probe(CMD_READ,  0,    0,  1,   0, OUT_PREDICTED, EVT_READ,  0,  0,   0,    0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < probes.size(); k++)
        begin
            issue(probes[k].it, probes[k].how, probes[k].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            pc = (ph == 1) ? 4'd0 : (ph == 2) ? 4'd15 : COLOR_W'($urandom_range(0, 15));
            set_window(pc, ROW_W'(win_top[ph]), ROW_W'(win_end[ph]));
            quiet = (ph == PHASES - 1);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 1 && k == 20)
                begin
                    hold_requests++;
                end
                if (ph == 2 && k == 30)
                begin
                    drain();
                end
                pick     = $urandom_range(0, 99);
                it.ch    = CHAR_W'($urandom_range(32, 126));
                it.row   = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(25, 31))
                                                       : ROW_W'($urandom_range(0, 24));
                it.col   = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(80, 127))
                                                       : COL_W'($urandom_range(0, 79));
                it.color = COLOR_W'($urandom_range(0, 15));
                if (pick < 62)
                begin
                    it.cmd = CMD_PRINT;
                    pick   = $urandom_range(0, 99);
                    if (pick < 10)
                    begin
                        it.ch = CHAR_NL;
                    end
                    else if (pick < 18)
                    begin
                        it.ch = CHAR_TAB;
                    end
                    else if (pick < 21)
                    begin
                        it.ch = CHAR_NUL;
                    end
                    else if (pick < 30)
                    begin
                        it.ch = CHAR_W'($urandom_range(0, 255));
                    end
                end
                else if (pick < 76)
                begin
                    it.cmd = CMD_PUT;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        it.ch = CHAR_W'($urandom_range(0, 255));
                    end
                end
                else if (pick < 96)
                begin
                    it.cmd = CMD_READ;
                    // read back around the cursor line
                    if ($urandom_range(0, 1) == 0)
                    begin
                        it.row = cur_line;
                    end
                end
                else
                begin
                    it.cmd = CMD_CLEAR;
                end
                issue(it, OUT_PREDICTED, none);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d commands over %0d window settings, %0d words checked, %0d scrolls",
                 items_sent, PHASES + 1, words_checked, scrolls_seen);
        $display("prints, tabs, newlines, puts, reads and clears, with cursor rows past the store");
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
